@@ rtl/core/ktm_pkg.sv @@
`default_nettype none

package ktm_pkg;

   localparam int ROWS_DEFAULT        = 8;
   localparam int COLUMNS_DEFAULT     = 16;
   localparam int VALUE_WIDTH_DEFAULT = 16;

   localparam int ROW_W       = 3;
   localparam int COL_W       = 4;
   localparam int VAL_W       = 16;
   localparam int LIMIT_W     = 16;
   localparam int LEN_W       = 7;   // holds a probe length up to the largest COLUMNS
   localparam int SLOT_W      = 6;
   localparam int CSR_INDEX_W = 1;

   localparam int QUEUE_DEPTH = 2;   // power of two, pointers wrap on their own
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_PROBE = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ELEMENT_LIMIT = 1'b0,
      CSR_AVERAGE_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic {
      CMD_TABLE = 1'b0,
      CMD_PROBE = 1'b1
   } cmd_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_WAIT,
      ST_DECIDE,
      ST_REPORT
   } back_state_type;

   typedef struct packed {
      logic             operation;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] column;
      logic [VAL_W-1:0] value;
      logic             last;
   } ktm_req_type;

   typedef struct packed {
      logic             matched;
      logic [ROW_W-1:0] match_row;
   } ktm_rsp_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  column;
      logic [VAL_W-1:0]  value;
      logic              store;
      logic              last;
      logic [SLOT_W-1:0] slot;
      logic [LEN_W-1:0]  len;
      logic              ovf;
   } ktm_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } ktm_q_status_type;

endpackage

`default_nettype wire

@@ rtl/core/ktm_ram.sv @@
`default_nettype none

module ktm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/ktm_front.sv @@
`default_nettype none

module ktm_front #(
   parameter int ROWS    = ktm_pkg::ROWS_DEFAULT,
   parameter int COLUMNS = ktm_pkg::COLUMNS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire ktm_pkg::ktm_req_type     req,
   input  wire ktm_pkg::ktm_q_status_type q_status,
   input  wire logic                     clearing,
   output logic                          busy,
   output logic                          push,
   output ktm_pkg::ktm_cmd_type          cmd
);

   import ktm_pkg::*;

   localparam int LW = $clog2(COLUMNS + 1);

   logic [LW-1:0] count_ff, count_in, count_inc;
   logic          ovf_ff, ovf_in;
   logic          accept, is_probe, has_slot, in_range;

   assign busy      = q_status.full | clearing;
   assign accept    = start & ~busy;
   assign is_probe  = (req.operation == OP_PROBE);
   assign has_slot  = (count_ff < LW'(COLUMNS));
   assign count_inc = has_slot ? count_ff + LW'(1) : count_ff;
   assign in_range  = (int'(req.row) < ROWS) && (int'(req.column) < COLUMNS);

   always_comb begin
      cmd.kind   = is_probe ? CMD_PROBE : CMD_TABLE;
      cmd.row    = req.row;
      cmd.column = req.column;
      cmd.value  = req.value;
      cmd.store  = is_probe ? has_slot : in_range;
      cmd.last   = is_probe & req.last;
      cmd.slot   = SLOT_W'(count_ff);
      cmd.len    = LEN_W'(count_inc);
      cmd.ovf    = ovf_ff | ~has_slot;
   end

   // out-of-range table writes are dropped here
   assign push = accept & (is_probe | in_range);

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (accept && is_probe) begin
         if (req.last) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            count_in = count_inc;
            ovf_in   = ovf_ff | ~has_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/ktm_queue.sv @@
`default_nettype none

module ktm_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire ktm_pkg::ktm_cmd_type      din,
   input  wire logic                      pop,
   output ktm_pkg::ktm_cmd_type           dout,
   output ktm_pkg::ktm_q_status_type      status
);

   import ktm_pkg::*;

   ktm_cmd_type            slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign status.empty = (cnt_ff == '0);
   assign status.full  = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign dout         = slot_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/ktm_back.sv @@
`default_nettype none

module ktm_back #(
   parameter int ROWS        = ktm_pkg::ROWS_DEFAULT,
   parameter int COLUMNS     = ktm_pkg::COLUMNS_DEFAULT,
   parameter int VALUE_WIDTH = ktm_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ktm_pkg::ktm_cmd_type         cmd,
   input  wire ktm_pkg::ktm_q_status_type    q_status,
   input  wire logic [ktm_pkg::LIMIT_W-1:0]  element_limit,
   input  wire logic [ktm_pkg::LIMIT_W-1:0]  average_limit,
   output logic                              pop,
   output logic                              clearing,
   output logic                              rsp_strobe,
   output ktm_pkg::ktm_rsp_type              rsp
);

   import ktm_pkg::*;

   localparam int DEPTH = ROWS * COLUMNS;
   localparam int TAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CLW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int LW    = $clog2(COLUMNS + 1);
   localparam int SUM_W = VALUE_WIDTH + LW;
   localparam int AVW   = LIMIT_W + LW;
   localparam int TW    = (SUM_W > AVW) ? SUM_W : AVW;
   localparam int CMPW  = (VALUE_WIDTH > LIMIT_W) ? VALUE_WIDTH : LIMIT_W;

   back_state_type state_ff, state_in;

   logic [TAW-1:0]         clr_ff, base_ff;
   logic [CLW-1:0]         col_ff, dcol_ff;
   logic [RW-1:0]          row_ff, hit_ff;
   logic [LW-1:0]          len_ff, nz_ff;
   logic [AVW-1:0]         lim_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic                   ovf_ff, dv_ff, fail_ff, found_ff;

   logic                   t_we, p_we;
   logic [TAW-1:0]         t_waddr, t_raddr;
   logic [CLW-1:0]         p_waddr, p_raddr;
   logic [VALUE_WIDTH-1:0] t_wdata, p_wdata, t_rdata, p_rdata, diff, cmd_value;
   logic                   col_last, clr_last, close_cmd, candidate;

   assign cmd_value = VALUE_WIDTH'(cmd.value);
   assign col_last  = (col_ff == CLW'(COLUMNS - 1));
   assign clr_last  = (clr_ff == TAW'(DEPTH - 1));
   assign close_cmd = (cmd.kind == CMD_PROBE) && cmd.last;
   assign diff      = (p_rdata >= t_rdata) ? p_rdata - t_rdata : t_rdata - p_rdata;
   // truncated mean <= limit  <=>  sum <= limit*len + len - 1
   assign candidate = (nz_ff == len_ff) && !fail_ff && (TW'(sum_ff) <= TW'(lim_ff));

   ktm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata),
      .rd_addr (t_raddr),
      .rd_data (t_rdata)
   );

   ktm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(COLUMNS)) u_probe (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  state_in = clr_last ? ST_IDLE : ST_CLEAR;
         ST_IDLE:   state_in = (!q_status.empty && close_cmd) ? ST_SETUP : ST_IDLE;
         ST_SETUP:  state_in = (ovf_ff || len_ff == '0) ? ST_REPORT : ST_SCAN;
         ST_SCAN:   state_in = col_last ? ST_WAIT : ST_SCAN;
         ST_WAIT:   state_in = ST_DECIDE;
         ST_DECIDE: state_in = (candidate || row_ff == '0) ? ST_REPORT : ST_SCAN;
         ST_REPORT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop        = 1'b0;
      clearing   = 1'b0;
      rsp_strobe = 1'b0;
      t_we       = 1'b0;
      t_waddr    = '0;
      t_wdata    = '0;
      t_raddr    = '0;
      p_we       = 1'b0;
      p_waddr    = '0;
      p_wdata    = cmd_value;
      p_raddr    = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            clearing = 1'b1;
            t_we     = 1'b1;
            t_waddr  = clr_ff;
         end
         ST_IDLE: begin
            pop = !q_status.empty;
            if (!q_status.empty && cmd.store) begin
               if (cmd.kind == CMD_TABLE) begin
                  t_we    = 1'b1;
                  t_waddr = TAW'(int'(cmd.row) * COLUMNS + int'(cmd.column));
                  t_wdata = cmd_value;
               end else begin
                  p_we    = 1'b1;
                  p_waddr = CLW'(cmd.slot);
               end
            end
         end
         ST_SCAN: begin
            t_raddr = base_ff + TAW'(col_ff);
            p_raddr = col_ff;
         end
         ST_REPORT: rsp_strobe = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         dv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         dv_ff    <= (state_ff == ST_SCAN);
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + TAW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      dcol_ff <= col_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty && close_cmd) begin
               len_ff <= LW'(cmd.len);
               ovf_ff <= cmd.ovf;
            end
         end
         ST_SETUP: begin
            lim_ff   <= AVW'(average_limit) * AVW'(len_ff) + AVW'(len_ff) - AVW'(1);
            row_ff   <= RW'(ROWS - 1);
            base_ff  <= TAW'((ROWS - 1) * COLUMNS);
            col_ff   <= '0;
            nz_ff    <= '0;
            sum_ff   <= '0;
            fail_ff  <= 1'b0;
            found_ff <= 1'b0;
            hit_ff   <= '0;
         end
         ST_SCAN: begin
            col_ff <= col_last ? '0 : col_ff + CLW'(1);
         end
         ST_DECIDE: begin
            if (candidate) begin
               found_ff <= 1'b1;
               hit_ff   <= row_ff;
            end else if (row_ff != '0) begin
               row_ff  <= row_ff - RW'(1);
               base_ff <= base_ff - TAW'(COLUMNS);
               nz_ff   <= '0;
               sum_ff  <= '0;
               fail_ff <= 1'b0;
            end
         end
         default: ;
      endcase
      // data stage: only live during SCAN and WAIT, never with SETUP or DECIDE
      if (dv_ff) begin
         nz_ff <= nz_ff + LW'(t_rdata != '0);
         if (LW'(dcol_ff) < len_ff) begin
            sum_ff <= sum_ff + SUM_W'(diff);
            if (CMPW'(diff) > CMPW'(element_limit)) begin
               fail_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.matched   = found_ff;
   assign rsp.match_row = ROW_W'(hit_ff);

endmodule

`default_nettype wire

@@ rtl/core/knock_template_matcher.sv @@
// Closing probe beat: with the back end idle, it goes SETUP, then SCAN, WAIT, DECIDE per row walked
// from the top (at most ROWS rows), then strobes the result in REPORT; on overflow SETUP goes straight to REPORT.
// Other beats are taken by the back end in its IDLE state; a two-entry queue takes beats while it works.
// Throughput is set by the row walk: one table entry read per cycle through the RAM port.
// Reset: synchronous; then a clearing pass over all ROWS*COLUMNS table entries holds busy high.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none

module knock_template_matcher #(
   parameter int ROWS        = ktm_pkg::ROWS_DEFAULT,
   parameter int COLUMNS     = ktm_pkg::COLUMNS_DEFAULT,
   parameter int VALUE_WIDTH = ktm_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire ktm_pkg::ktm_req_type            req_item,
   output logic                                 rsp_strobe,
   output ktm_pkg::ktm_rsp_type                 rsp_item,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [ktm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ktm_pkg::LIMIT_W-1:0]     csr_data
);

   import ktm_pkg::*;

   logic [LIMIT_W-1:0] element_limit_ff, average_limit_ff;
   ktm_cmd_type        push_cmd, head_cmd;
   ktm_q_status_type   q_status;
   logic               push, pop, clearing;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         element_limit_ff <= '0;
         average_limit_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ELEMENT_LIMIT: element_limit_ff <= csr_data;
            CSR_AVERAGE_LIMIT: average_limit_ff <= csr_data;
         endcase
      end
   end

   ktm_front #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req_item),
      .q_status (q_status),
      .clearing (clearing),
      .busy     (busy),
      .push     (push),
      .cmd      (push_cmd)
   );

   ktm_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .din    (push_cmd),
      .pop    (pop),
      .dout   (head_cmd),
      .status (q_status)
   );

   ktm_back #(.ROWS(ROWS), .COLUMNS(COLUMNS), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd           (head_cmd),
      .q_status      (q_status),
      .element_limit (element_limit_ff),
      .average_limit (average_limit_ff),
      .pop           (pop),
      .clearing      (clearing),
      .rsp_strobe    (rsp_strobe),
      .rsp           (rsp_item)
   );

endmodule

`default_nettype wire

@@ rtl/core/ktm_checker.sv @@
`default_nettype none

module ktm_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 busy,
   input wire logic                 rsp_strobe,
   input wire ktm_pkg::ktm_rsp_type rsp_item
);

   import ktm_pkg::*;

   // clearing pass follows every reset
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   a_no_strobe_after_reset: assert property (@(posedge clock) rsp_strobe |-> !$past(reset))
      else $error("result strobe right after reset");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held two cycles");

   a_row_zero_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.matched) |-> (rsp_item.match_row == '0))
      else $error("nonzero row without a match");

endmodule

bind knock_template_matcher ktm_checker u_ktm_checker (
   .clock      (clock),
   .reset      (reset),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

`default_nettype wire

@@ tb/tb_knock_template_matcher.sv @@
module tb_knock_template_matcher;
   import ktm_pkg::*;

   localparam int N_ROWS      = ROWS_DEFAULT;
   localparam int N_COLS      = COLUMNS_DEFAULT;
   localparam int SETTLE      = 200;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_BEATS = 95;
   localparam int N_PHASES    = 8;

   typedef struct {
      ktm_req_type item;
      int          reps;
      bit          typed;
      ktm_rsp_type want;
   } plan_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   ktm_req_type            req_item = '0;
   logic                   rsp_strobe;
   ktm_rsp_type            rsp_item;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [LIMIT_W-1:0]     csr_data = '0;

   // shadow of the matcher
   logic [VAL_W-1:0]   tmpl [N_ROWS][N_COLS];
   logic [VAL_W-1:0]   probe_vals [N_COLS];
   int                 probe_len = 0;
   bit                 probe_ovf = 1'b0;
   logic [LIMIT_W-1:0] elem_limit = '0;
   logic [LIMIT_W-1:0] avg_limit = '0;

   ktm_rsp_type  pending_matches [$];
   ktm_rsp_type  oldest_match;
   plan_row_type plan [14];
   int           failures = 0;
   int           beats_sent = 0;
   int           cycle_count = 0;
   bit           no_gaps = 1'b0;

   knock_template_matcher dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_knock_template_matcher failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (rsp_strobe === 1'b1) begin
         if (pending_matches.size() == 0) begin
            $error("unexpected result: matched %0d match_row %0d",
                   rsp_item.matched, rsp_item.match_row);
            failures++;
         end else begin
            oldest_match = pending_matches.pop_front();
            if (rsp_item.matched !== oldest_match.matched) begin
               $error("matched: expected %0d, actual %0d",
                      oldest_match.matched, rsp_item.matched);
               failures++;
            end
            if (rsp_item.match_row !== oldest_match.match_row) begin
               $error("match_row: expected %0d, actual %0d",
                      oldest_match.match_row, rsp_item.match_row);
               failures++;
            end
         end
      end
   end

   function automatic ktm_req_type make_beat(logic op, int row, int col,
                                             logic [VAL_W-1:0] value, logic last);
      ktm_req_type it;
      it.operation = op;
      it.row       = ROW_W'(row);
      it.column    = COL_W'(col);
      it.value     = value;
      it.last      = last;
      return it;
   endfunction

   function automatic int row_weight(int r);
      int n;
      n = 0;
      for (int c = 0; c < N_COLS; c++)
         if (tmpl[r][c] != 0) n++;
      return n;
   endfunction

   function automatic void advance_matcher(input ktm_req_type it, output bit produced,
                                           output ktm_rsp_type res);
      int total;
      int d;
      bit fits;
      produced = 1'b0;
      res = '0;
      if (it.operation == OP_WRITE) begin
         tmpl[it.row][it.column] = it.value;
         return;
      end
      if (probe_len < N_COLS) begin
         probe_vals[probe_len] = it.value;
         probe_len++;
      end else begin
         probe_ovf = 1'b1;
      end
      if (!it.last) return;
      produced = 1'b1;
      if (!probe_ovf) begin
         for (int r = N_ROWS - 1; r >= 0 && !res.matched; r--) begin
            if (row_weight(r) == probe_len) begin
               fits = 1'b1;
               total = 0;
               for (int c = 0; c < probe_len; c++) begin
                  d = probe_vals[c] >= tmpl[r][c] ? int'(probe_vals[c]) - int'(tmpl[r][c])
                                                  : int'(tmpl[r][c]) - int'(probe_vals[c]);
                  if (d > int'(elem_limit)) fits = 1'b0;
                  total += d;
               end
               if (fits && total / probe_len <= int'(avg_limit)) begin
                  res.matched   = 1'b1;
                  res.match_row = ROW_W'(r);
               end
            end
         end
      end
      probe_len = 0;
      probe_ovf = 1'b0;
   endfunction

   function automatic int idle_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [VAL_W-1:0] rand_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return VAL_W'($urandom_range(1, 15));
         default: return VAL_W'($urandom);
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] near_value(logic [VAL_W-1:0] base);
      int span;
      logic [VAL_W-1:0] offset;
      span = int'(elem_limit) > 1000 ? 1000 : int'(elem_limit) + 1;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: offset = VAL_W'($urandom_range(0, span));
         6, 7, 8: offset = VAL_W'($urandom_range(0, 3));
         default: offset = VAL_W'($urandom);
      endcase
      return $urandom_range(0, 1) ? base + offset : base - offset;
   endfunction

   task automatic drive_beat(input ktm_req_type it, input bit typed = 1'b0,
                             input ktm_rsp_type want = '0);
      int gap;
      bit produced;
      ktm_rsp_type res;
      gap = idle_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      beats_sent++;
      advance_matcher(it, produced, res);
      if (produced) pending_matches.push_back(typed ? want : res);
   endtask

   task automatic set_limits(input logic [LIMIT_W-1:0] e, input logic [LIMIT_W-1:0] a);
      csr_valid <= 1'b1;
      csr_index <= CSR_ELEMENT_LIMIT;
      csr_data <= e;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      elem_limit = e;
      csr_index <= CSR_AVERAGE_LIMIT;
      csr_data <= a;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      avg_limit = a;
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      start <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic send_probe(int len, int src);
      logic [VAL_W-1:0] v;
      for (int c = 0; c < len; c++) begin
         v = (src >= 0 && c < N_COLS) ? near_value(tmpl[src][c]) : rand_value();
         drive_beat(make_beat(OP_PROBE, $urandom_range(0, 7), $urandom_range(0, 15),
                              v, c == len - 1));
      end
   endtask

   task automatic play_episode();
      int kind;
      int r;
      int len;
      int other;
      logic [VAL_W-1:0] v;
      kind = $urandom_range(0, 99);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (kind < 55) begin
         // build a row of the wanted weight, then probe close to it
         r = $urandom_range(0, N_ROWS - 1);
         case ($urandom_range(0, 19)) inside
            [0:13]:  len = $urandom_range(1, 5);
            [14:18]: len = $urandom_range(6, N_COLS - 1);
            default: len = N_COLS;
         endcase
         for (int c = 0; c < len; c++) begin
            if ($urandom_range(0, 3) != 0 || tmpl[r][c] == 0) begin
               v = rand_value();
               if (v == 0) v = 1;
               drive_beat(make_beat(OP_WRITE, r, c, v, 1'($urandom_range(0, 1))));
            end
         end
         for (int c = len; c < N_COLS; c++)
            if (tmpl[r][c] != 0)
               drive_beat(make_beat(OP_WRITE, r, c, '0, 1'($urandom_range(0, 1))));
         for (int c = 0; c < len; c++) begin
            if ($urandom_range(0, 9) == 0) begin
               other = (r + $urandom_range(1, N_ROWS - 1)) % N_ROWS;
               drive_beat(make_beat(OP_WRITE, other, $urandom_range(0, 15), rand_value(),
                                    1'($urandom_range(0, 1))));
            end
            drive_beat(make_beat(OP_PROBE, $urandom_range(0, 7), $urandom_range(0, 15),
                                 near_value(tmpl[r][c]), c == len - 1));
         end
      end else if (kind < 72) begin
         r = $urandom_range(0, N_ROWS - 1);
         len = $urandom_range(0, 1) ? row_weight(r) : $urandom_range(1, N_COLS);
         if (len == 0) len = 1;
         send_probe(len, $urandom_range(0, 1) ? r : -1);
      end else if (kind < 77) begin
         send_probe($urandom_range(N_COLS + 1, N_COLS + 4), -1);
      end else begin
         repeat ($urandom_range(1, 4))
            drive_beat(make_beat(OP_WRITE, $urandom_range(0, 7), $urandom_range(0, 15),
                                 rand_value(), 1'($urandom_range(0, 1))));
      end
   endtask

   initial begin
      int unsigned elem_cfg [N_PHASES];
      int unsigned avg_cfg [N_PHASES];
      int target;
      elem_cfg = '{0, 65535, 65535, 0, 40, 1000, 3, 0};
      avg_cfg  = '{0, 65535, 0, 65535, 10, 300, 1, 0};
      foreach (tmpl[r, c]) tmpl[r][c] = '0;
      foreach (probe_vals[c]) probe_vals[c] = '0;

      // limits at zero: only exact rows match
      plan[0]  = '{make_beat(OP_PROBE, 0, 0, 16'h0000, 1), 1, 1, '{1'b0, 3'd0}};
      plan[1]  = '{make_beat(OP_WRITE, 7, 0, 16'hFFFF, 0), 1, 0, '0};
      plan[2]  = '{make_beat(OP_WRITE, 7, 1, 16'h8000, 1), 1, 0, '0};
      plan[3]  = '{make_beat(OP_PROBE, 7, 15, 16'hFFFF, 0), 1, 0, '0};
      plan[4]  = '{make_beat(OP_WRITE, 0, 0, 16'h0001, 1), 1, 0, '0};
      plan[5]  = '{make_beat(OP_PROBE, 0, 0, 16'h8000, 1), 1, 1, '{1'b1, 3'd7}};
      plan[6]  = '{make_beat(OP_PROBE, 3, 9, 16'h0001, 1), 1, 1, '{1'b1, 3'd0}};
      plan[7]  = '{make_beat(OP_PROBE, 0, 0, 16'h0002, 1), 1, 0, '0};
      plan[8]  = '{make_beat(OP_WRITE, 3, 15, 16'h0001, 0), 1, 0, '0};
      plan[9]  = '{make_beat(OP_PROBE, 5, 5, 16'h0000, 1), 1, 0, '0};
      plan[10] = '{make_beat(OP_PROBE, 2, 6, 16'hAAAA, 0), 16, 0, '0};
      plan[11] = '{make_beat(OP_PROBE, 5, 9, 16'h5555, 1), 1, 1, '{1'b0, 3'd0}};
      plan[12] = '{make_beat(OP_WRITE, 7, 1, 16'h0000, 0), 1, 0, '0};
      plan[13] = '{make_beat(OP_PROBE, 7, 15, 16'hFFFF, 1), 1, 0, '0};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      set_limits(LIMIT_W'(elem_cfg[0]), LIMIT_W'(avg_cfg[0]));
      foreach (plan[i])
         repeat (plan[i].reps) drive_beat(plan[i].item, plan[i].typed, plan[i].want);

      for (int p = 0; p < N_PHASES; p++) begin
         if (p > 0) begin
            settle();
            if (p == N_PHASES - 1)
               set_limits(LIMIT_W'($urandom_range(0, 200)), LIMIT_W'($urandom_range(0, 100)));
            else
               set_limits(LIMIT_W'(elem_cfg[p]), LIMIT_W'(avg_cfg[p]));
         end
         target = beats_sent + PHASE_BEATS;
         while (beats_sent < target) play_episode();
      end
      settle();

      if (failures == 0)
         $display("tb_knock_template_matcher passed");
      else
         $display("tb_knock_template_matcher failed");
      $finish;
   end

endmodule

@@ knock_template_matcher.f @@
rtl/core/ktm_pkg.sv
rtl/core/ktm_ram.sv
rtl/core/ktm_front.sv
rtl/core/ktm_queue.sv
rtl/core/ktm_back.sv
rtl/core/knock_template_matcher.sv
rtl/core/ktm_checker.sv
tb/tb_knock_template_matcher.sv
